/* sv/dobr_pkg.sv */
// Shared types and codes for the dual-order bit reader.
// No dependencies; the reader RTL and its testbench use this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package dobr_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_GET  = 2'd1,
    FUNC_SKIP = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic ORDER_MSB_FIRST = 1'b0;
  localparam logic ORDER_LSB_FIRST = 1'b1;

  localparam int unsigned FIELD_W   = 64;
  localparam int unsigned WINDOW_W  = 72;   // nine bytes cover 64 bits at any offset
  localparam logic [6:0]  MAX_GET   = 7'd64;

endpackage

`default_nettype wire

/* sv/dobr_if.sv */
// Valid/ready channel interfaces for the dual-order bit reader.
// Depends on nothing; used by dual_order_bit_reader.
`timescale 1ns / 1ps
`default_nettype none

interface dobr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic [6:0] bit_count;
  modport source (output valid, func, data_byte, bit_count, input ready);
  modport sink   (input valid, func, data_byte, bit_count, output ready);
endinterface

interface dobr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] field_value;
  logic [1:0]  status;
  modport source (output valid, field_value, status, input ready);
  modport sink   (input valid, field_value, status, output ready);
endinterface

interface dobr_cfg_if;
  logic valid;
  logic ready;
  logic bit_order;
  modport source (output valid, bit_order, input ready);
  modport sink   (input valid, bit_order, output ready);
endinterface

`default_nettype wire

/* sv/dual_order_bit_reader.sv */
// Top level of the dual-order bit reader: byte FIFO, field extractor, result register.
// Depends on dobr_pkg and the channel interfaces in dobr_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Bit reader over a byte stream. Push items append a byte; get items return
// 0..64 bits, skip items drop 0..127 bits. bit_order (reset 1) selects
// LSB-first/little-endian (1) or MSB-first/big-endian (0) fields. One item is
// taken every cycle unless the output stalls; it goes through the input register,
// then the result register. The buffer is kept head-aligned, so each cycle's work
// is one byte barrel shift of the BUFFER_BYTES-byte buffer plus a 72-bit window
// shift for the extracted field. Func code 3 is taken and yields no result.
module dual_order_bit_reader #(
  parameter int unsigned BUFFER_BYTES = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dobr_in_if.sink     in_ch,
  dobr_out_if.source  out_ch,
  dobr_cfg_if.sink    cfg_ch
);

  localparam int unsigned BUF_W = BUFFER_BYTES * 8;
  localparam int unsigned UW    = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned HW    = UW + 3;
  localparam int unsigned CW    = (HW > 7) ? HW : 7;

  // input stage
  logic                 s1_valid_r;
  dobr_pkg::func_t      s1_func_r;
  logic [7:0]           s1_byte_r;
  logic [6:0]           s1_count_r;

  // buffer state, slot 0 is always the head byte
  logic [BUF_W-1:0]     buf_r, buf_nxt;
  logic [UW-1:0]        used_r, used_nxt;
  logic [2:0]           off_r, off_nxt;
  logic                 order_r;

  // result stage
  logic                 out_valid_r;
  logic [63:0]          out_value_r, out_value_nxt;
  dobr_pkg::status_t    out_status_r, out_status_nxt;

  logic                 out_free, s1_fire, in_fire;
  logic [CW-1:0]        held_ext, count_ext;
  logic [HW-1:0]        bits_held;
  logic                 short_get, short_skip;
  logic [dobr_pkg::WINDOW_W-1:0] win_be, win_le, be_sh, le_sh;
  logic [63:0]          be_val, le_val, le_mask;
  logic [7:0]           pos;
  logic [4:0]           whole;
  logic [UW-1:0]        used_after;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.field_value = out_value_r;
  assign out_ch.status      = out_status_r;

  assign bits_held  = {used_r, 3'b000} - HW'(off_r);
  assign held_ext   = CW'(bits_held);
  assign count_ext  = CW'(s1_count_r);
  assign short_skip = count_ext > held_ext;
  assign short_get  = short_skip || (s1_count_r > dobr_pkg::MAX_GET);

  // nine-byte window from the head, in both byte orders
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win_be[(8 - i) * 8 +: 8] = buf_r[i * 8 +: 8];
      win_le[i * 8 +: 8]       = buf_r[i * 8 +: 8];
    end
  end

  // MSB-first: top n bits after dropping the consumed ones
  assign be_sh  = win_be << off_r;
  assign be_val = be_sh[dobr_pkg::WINDOW_W-1:8] >> (dobr_pkg::MAX_GET - s1_count_r);
  // LSB-first: low n bits after dropping the consumed ones
  assign le_sh   = win_le >> off_r;
  assign le_mask = ~({64{1'b1}} << s1_count_r);
  assign le_val  = le_sh[63:0] & le_mask;

  assign pos        = {5'b00000, off_r} + {1'b0, s1_count_r};
  assign whole      = pos[7:3];
  assign used_after = used_r - UW'(whole);

  always_comb begin
    buf_nxt        = buf_r;
    used_nxt       = used_r;
    off_nxt        = off_r;
    out_value_nxt  = '0;
    out_status_nxt = dobr_pkg::ST_OK;
    unique case (s1_func_r) inside
      dobr_pkg::FUNC_PUSH: begin
        if (used_r >= UW'(BUFFER_BYTES)) begin
          out_status_nxt = dobr_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < BUFFER_BYTES; i++) begin
            if (UW'(i) == used_r) buf_nxt[i * 8 +: 8] = s1_byte_r;
          end
          used_nxt = used_r + UW'(1);
        end
      end
      dobr_pkg::FUNC_GET, dobr_pkg::FUNC_SKIP: begin
        if ((s1_func_r == dobr_pkg::FUNC_GET) ? short_get : short_skip) begin
          out_status_nxt = dobr_pkg::ST_SHORT;
        end else begin
          if (s1_func_r == dobr_pkg::FUNC_GET) begin
            out_value_nxt = (order_r == dobr_pkg::ORDER_MSB_FIRST) ? be_val : le_val;
          end
          buf_nxt  = buf_r >> {whole, 3'b000};
          used_nxt = used_after;
          off_nxt  = (used_after == '0) ? 3'd0 : pos[2:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      off_r       <= 3'd0;
      order_r     <= dobr_pkg::ORDER_LSB_FIRST;
    end else begin
      if (cfg_ch.valid) order_r <= cfg_ch.bit_order;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire && s1_func_r != dobr_pkg::FUNC_NONE) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        used_r <= used_nxt;
        off_r  <= off_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r  <= dobr_pkg::func_t'(in_ch.func);
      s1_byte_r  <= in_ch.data_byte;
      s1_count_r <= in_ch.bit_count;
    end
    if (s1_fire) begin
      buf_r <= buf_nxt;
      if (s1_func_r != dobr_pkg::FUNC_NONE) begin
        out_value_r  <= out_value_nxt;
        out_status_r <= out_status_nxt;
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(BUFFER_BYTES))
    else $error("slot count beyond buffer size");

  a_empty_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r == '0) |-> (off_r == 3'd0))
    else $error("bit offset left in an empty buffer");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != dobr_pkg::ST_OK) |-> (out_value_r == '0))
    else $error("error result carries a field value");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |=> s1_valid_r)
    else $error("input stage item lost during output stall");

endmodule

`default_nettype wire

/* tb/dual_order_bit_reader_tb.sv */
// Self-checking testbench for dual_order_bit_reader: a directed table and random phases
// under both bit orders, checked against a behavioral field predictor.
// Depends on dobr_pkg, the channel interfaces in dobr_if.sv and the reader RTL.
`timescale 1ns / 1ps

module dual_order_bit_reader_tb;

  localparam int unsigned BUF_BYTES   = 16;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned PHASE_ITEMS = 171;
  localparam int unsigned DRAIN_WAIT  = 4;
  localparam int unsigned TIMEOUT_NS  = 4_000_000;

  typedef struct {
    logic [63:0]       value;
    dobr_pkg::status_t status;
  } field_result_t;

  typedef struct {
    dobr_pkg::func_t   f;
    logic [7:0]        b;
    logic [6:0]        n;
    bit                typed;
    logic [63:0]       v;
    dobr_pkg::status_t s;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  dobr_in_if  in_if ();
  dobr_out_if out_if ();
  dobr_cfg_if cfg_if ();

  dual_order_bit_reader #(.BUFFER_BYTES(BUF_BYTES)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [7:0]  fifo_bytes [BUF_BYTES];
  int unsigned rd_slot;
  int unsigned slots_used;
  int unsigned rd_offset;
  int unsigned bits_avail;
  logic        order_q;

  field_result_t pending_fields[$];
  stim_row_t     directed_rows[$];
  int unsigned   fail_count;

  // traffic shaping flags, written at the falling edge
  bit quiet;
  bit hold_req;
  int unsigned push_pct;

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic drop_bits(input int unsigned n);
    int unsigned pos;
    pos = rd_offset + n;
    rd_slot = (rd_slot + pos / 8) % BUF_BYTES;
    slots_used -= pos / 8;
    rd_offset = pos % 8;
    bits_avail -= n;
    if (slots_used == 0) begin
      rd_offset = 0;
      bits_avail = 0;
    end
  endtask

  task automatic predict_field(input dobr_pkg::func_t f, input logic [7:0] b,
                               input logic [6:0] n,
                               output bit produced, output logic [63:0] val,
                               output dobr_pkg::status_t st);
    int unsigned pos;
    logic [7:0] cur;
    produced = 1'b1;
    val = '0;
    st = dobr_pkg::ST_OK;
    case (f)
      dobr_pkg::FUNC_PUSH: begin
        if (slots_used >= BUF_BYTES) begin
          st = dobr_pkg::ST_FULL;
        end else begin
          fifo_bytes[(rd_slot + slots_used) % BUF_BYTES] = b;
          slots_used++;
          bits_avail += 8;
        end
      end
      dobr_pkg::FUNC_GET: begin
        if (n > dobr_pkg::MAX_GET || n > bits_avail) begin
          st = dobr_pkg::ST_SHORT;
        end else begin
          for (int k = 0; k < n; k++) begin
            pos = rd_offset + k;
            cur = fifo_bytes[(rd_slot + pos / 8) % BUF_BYTES];
            if (order_q == dobr_pkg::ORDER_MSB_FIRST) val = {val[62:0], cur[7 - pos % 8]};
            else val[k] = cur[pos % 8];
          end
          drop_bits(n);
        end
      end
      dobr_pkg::FUNC_SKIP: begin
        if (n > bits_avail) st = dobr_pkg::ST_SHORT;
        else drop_bits(n);
      end
      default: produced = 1'b0;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  // valid stays high into the next call unless the caller lowers it.
  task automatic send_item(input dobr_pkg::func_t f, input logic [7:0] b,
                           input logic [6:0] n, input bit typed, input logic [63:0] tv,
                           input dobr_pkg::status_t ts);
    bit produced;
    logic [63:0] val;
    dobr_pkg::status_t st;
    while (!quiet && $urandom_range(99) < 6) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.func      = f;
    in_if.data_byte = b;
    in_if.bit_count = n;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_field(f, b, n, produced, val, st);
    if (typed) begin
      val = tv;
      st = ts;
      produced = (f != dobr_pkg::FUNC_NONE);
    end
    if (produced) pending_fields.push_back('{value: val, status: st});
    @(negedge clk);
  endtask

  task automatic add_row(input dobr_pkg::func_t f, input logic [7:0] b,
                         input logic [6:0] n, input bit typed, input logic [63:0] v,
                         input dobr_pkg::status_t s);
    directed_rows.push_back('{f: f, b: b, n: n, typed: typed, v: v, s: s});
  endtask

  // Lower valid and wait out every result plus the pipeline, including func-3 items.
  task automatic drain_results();
    in_if.valid = 1'b0;
    while (pending_fields.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_order(input logic ord);
    cfg_if.valid     = 1'b1;
    cfg_if.bit_order = ord;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    order_q = ord;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Mostly well-formed requests sized to what is buffered, with some noise.
  task automatic pick_item(output dobr_pkg::func_t f, output logic [7:0] b,
                           output logic [6:0] n);
    int unsigned r;
    int unsigned lim;
    r = $urandom_range(99);
    lim = (bits_avail > 64) ? 64 : bits_avail;
    b = 8'($urandom_range(255));
    n = 7'($urandom_range(127));
    if (r < 3) begin
      f = dobr_pkg::FUNC_NONE;
    end else if (r < push_pct) begin
      f = dobr_pkg::FUNC_PUSH;
    end else if (r < push_pct + (100 - push_pct) * 2 / 3) begin
      f = dobr_pkg::FUNC_GET;
      if ($urandom_range(9) != 0) n = 7'($urandom_range(lim));
    end else begin
      f = dobr_pkg::FUNC_SKIP;
      if ($urandom_range(9) != 0)
        n = 7'($urandom_range(lim > 16 ? 16 : lim));
      else if ($urandom_range(1) == 0)
        n = 7'($urandom_range(bits_avail > 127 ? 127 : bits_avail));
    end
  endtask

  // result side: random stalls, a quiet mode and one long hold-off on request
  initial begin : result_sink
    bit take_hold;
    bit calm;
    out_if.ready = 1'b1;
    forever begin
      @(posedge clk);
      take_hold = hold_req;
      calm = quiet;
      @(negedge clk);
      if (take_hold) begin
        hold_req = 1'b0;
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_if.ready = 1'b1;
      end else begin
        out_if.ready = calm || ($urandom_range(99) >= 6);
      end
    end
  end

  always @(posedge clk) begin : result_check
    field_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_fields.size() == 0) begin
        flag_error($sformatf("unexpected item: value %h status %0d",
                             out_if.field_value, out_if.status));
      end else begin
        want = pending_fields.pop_front();
        if (out_if.field_value !== want.value)
          flag_error($sformatf("field_value: expected %h, got %h",
                               want.value, out_if.field_value));
        if (out_if.status !== want.status)
          flag_error($sformatf("status: expected %0d, got %0d",
                               want.status, out_if.status));
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    dobr_pkg::func_t f;
    logic [7:0] b;
    logic [6:0] n;
    stim_row_t row;
    logic [7:0] fill [16];

    fill = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hA5, 8'h5A, 8'h3C, 8'hC3,
             8'h0F, 8'hF0, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hDE};
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.func = dobr_pkg::FUNC_PUSH;
    in_if.data_byte = '0;
    in_if.bit_count = '0;
    cfg_if.valid = 1'b0;
    cfg_if.bit_order = dobr_pkg::ORDER_LSB_FIRST;
    quiet = 1'b0;
    hold_req = 1'b0;
    push_pct = 50;
    fail_count = 0;
    order_q = dobr_pkg::ORDER_LSB_FIRST;
    rd_slot = 0;
    slots_used = 0;
    rd_offset = 0;
    bits_avail = 0;
    foreach (fifo_bytes[i]) fifo_bytes[i] = '0;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed part, reset order (LSB-first)
    add_row(dobr_pkg::FUNC_GET,  8'h00, 7'd0,   1, 64'd0, dobr_pkg::ST_OK);
    add_row(dobr_pkg::FUNC_GET,  8'h00, 7'd1,   1, 64'd0, dobr_pkg::ST_SHORT);
    add_row(dobr_pkg::FUNC_SKIP, 8'h00, 7'd1,   1, 64'd0, dobr_pkg::ST_SHORT);
    add_row(dobr_pkg::FUNC_NONE, 8'hFF, 7'd127, 1, 64'd0, dobr_pkg::ST_OK);
    foreach (fill[i]) add_row(dobr_pkg::FUNC_PUSH, fill[i], 7'd0, 1, 64'd0, dobr_pkg::ST_OK);
    add_row(dobr_pkg::FUNC_PUSH, 8'hBC, 7'd0,   1, 64'd0, dobr_pkg::ST_FULL);
    add_row(dobr_pkg::FUNC_GET,  8'h00, 7'd3,   0, 64'd0, dobr_pkg::ST_OK);
    // full even with the head byte partly read
    add_row(dobr_pkg::FUNC_PUSH, 8'h77, 7'd0,   1, 64'd0, dobr_pkg::ST_FULL);
    add_row(dobr_pkg::FUNC_GET,  8'h00, 7'd70,  1, 64'd0, dobr_pkg::ST_SHORT);
    add_row(dobr_pkg::FUNC_SKIP, 8'h00, 7'd100, 1, 64'd0, dobr_pkg::ST_OK);
    add_row(dobr_pkg::FUNC_GET,  8'h00, 7'd25,  0, 64'd0, dobr_pkg::ST_OK);
    add_row(dobr_pkg::FUNC_GET,  8'h00, 7'd1,   1, 64'd0, dobr_pkg::ST_SHORT);
    add_row(dobr_pkg::FUNC_SKIP, 8'h00, 7'd0,   1, 64'd0, dobr_pkg::ST_OK);

    while (directed_rows.size() != 0) begin
      row = directed_rows.pop_front();
      send_item(row.f, row.b, row.n, row.typed, row.v, row.s);
    end

    // random phases, alternating bit order; leftover bits carry across order changes
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      write_order(ph % 2 == 0 ? dobr_pkg::ORDER_MSB_FIRST : dobr_pkg::ORDER_LSB_FIRST);
      quiet = (ph == 2);
      push_pct = (ph % 3 == 1) ? 70 : 45;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == 40) hold_req = 1'b1;
        pick_item(f, b, n);
        send_item(f, b, n, 0, 64'd0, dobr_pkg::ST_OK);
      end
    end
    quiet = 1'b0;

    in_if.valid = 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
sv/dobr_pkg.sv
sv/dobr_if.sv
sv/dual_order_bit_reader.sv
tb/dual_order_bit_reader_tb.sv
